// ===== hw/rtl/atlc_pkg.sv =====
// ----------------------------------------------------------------------------
// atlc_pkg
// Types, constants and helpers shared by the traffic light controller modules.
// ----------------------------------------------------------------------------
package atlc_pkg;

    localparam int LANES      = 4;
    localparam int COUNT_BITS = 10;

    localparam int LANE_BITS  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int OP_BITS    = 2;
    localparam int LANE_W     = 2;
    localparam int VEH_BITS   = 10;
    localparam int GREEN_BITS = 7;
    localparam int HOLD_BITS  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int REM_BITS   = 10;

    localparam int SUM_BITS   = ((COUNT_BITS > VEH_BITS) ? COUNT_BITS : VEH_BITS) + 1;
    localparam int CLAMP_BITS = (COUNT_BITS > GREEN_BITS) ? COUNT_BITS : GREEN_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [GREEN_BITS-1:0] MIN_GREEN_RST       = GREEN_BITS'(10);
    localparam logic [GREEN_BITS-1:0] MAX_GREEN_RST       = GREEN_BITS'(90);
    localparam logic [HOLD_BITS-1:0]  EMERGENCY_TICKS_RST = HOLD_BITS'(5);

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK      = 2'd0,
        OP_ARRIVAL   = 2'd1,
        OP_EMERGENCY = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_GREEN       = 2'd0,
        REG_MAX_GREEN       = 2'd1,
        REG_EMERGENCY_TICKS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GREEN_BITS-1:0] min_green;
        logic [GREEN_BITS-1:0] max_green;
        logic [HOLD_BITS-1:0]  emergency_ticks;
    } cfg_t;

    typedef struct packed {
        logic [OP_BITS-1:0]  operation;
        logic [LANE_W-1:0]   lane;
        logic [VEH_BITS-1:0] vehicles;
    } item_t;

    typedef struct packed {
        logic [LANE_W-1:0]     current_lane;
        logic                  light_green;
        logic                  vehicle_passed;
        logic [REM_BITS-1:0]   lane_remaining;
        logic [GREEN_BITS-1:0] green_left;
        logic                  emergency_hold;
        logic                  idle;
    } res_t;

    function automatic logic [LANE_BITS-1:0] next_lane(input logic [LANE_BITS-1:0] l);
        logic [LANE_BITS-1:0] n;
        if (l == LANE_BITS'(LANES - 1)) begin
            n = '0;
        end else begin
            n = l + LANE_BITS'(1);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/adaptive_traffic_light_controller.sv =====
// ----------------------------------------------------------------------------
// adaptive_traffic_light_controller
// Four-lane green-phase sequencer with arrivals, ticks and emergency hold.
// ----------------------------------------------------------------------------
// One word is taken per clock cycle, back to back, while the output does not
// stall. An accepted word waits in the input register; when the result register
// is free or being taken, the controller state (lane counts, green lane, green
// ticks, emergency hold) is updated while the word's result moves into the
// result register, from which it is presented. The result stays there until
// taken; while it waits, one more word can sit in the input register before the
// input stalls. The state update sets the throughput of one word per cycle.
// Configuration writes are accepted at any time and should only be issued
// while the block is idle.
module adaptive_traffic_light_controller (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [atlc_pkg::OP_BITS-1:0]     s_operation,
    input  logic [atlc_pkg::LANE_W-1:0]      s_lane,
    input  logic [atlc_pkg::VEH_BITS-1:0]    s_vehicles,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [atlc_pkg::LANE_W-1:0]      m_current_lane,
    output logic                             m_light_green,
    output logic                             m_vehicle_passed,
    output logic [atlc_pkg::REM_BITS-1:0]    m_lane_remaining,
    output logic [atlc_pkg::GREEN_BITS-1:0]  m_green_left,
    output logic                             m_emergency_hold,
    output logic                             m_idle,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atlc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atlc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import atlc_pkg::*;

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  res_reg;
    logic  m_valid_reg;
    logic  advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    atlc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    atlc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .step_en (advance),
        .res     (res)
    );

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.operation <= s_operation;
            in_item_reg.lane      <= s_lane;
            in_item_reg.vehicles  <= s_vehicles;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_current_lane   = res_reg.current_lane;
    assign m_light_green    = res_reg.light_green;
    assign m_vehicle_passed = res_reg.vehicle_passed;
    assign m_lane_remaining = res_reg.lane_remaining;
    assign m_green_left     = res_reg.green_left;
    assign m_emergency_hold = res_reg.emergency_hold;
    assign m_idle           = res_reg.idle;

`ifndef ASSERT_OFF
    a_pass_needs_green: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_vehicle_passed || m_light_green))
        else $error("vehicle passed without green");

    a_hold_all_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_emergency_hold |-> !m_light_green && !m_idle)
        else $error("green or idle shown during emergency hold");

    a_no_step_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_valid_reg && !m_ready |=> in_valid_reg && $stable(res_reg))
        else $error("word lost or result overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/atlc_cfg.sv =====
// ----------------------------------------------------------------------------
// atlc_cfg
// Configuration registers: minimum green, maximum green, emergency hold length.
// ----------------------------------------------------------------------------
module atlc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [atlc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atlc_pkg::CFG_DATA_W-1:0] cfg_data,
    output atlc_pkg::cfg_t                  cfg
);
    import atlc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_GREEN:       cfg_next.min_green       = cfg_data[GREEN_BITS-1:0];
                REG_MAX_GREEN:       cfg_next.max_green       = cfg_data[GREEN_BITS-1:0];
                REG_EMERGENCY_TICKS: cfg_next.emergency_ticks = cfg_data[HOLD_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_green       <= MIN_GREEN_RST;
            cfg_reg.max_green       <= MAX_GREEN_RST;
            cfg_reg.emergency_ticks <= EMERGENCY_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/atlc_core.sv =====
// ----------------------------------------------------------------------------
// atlc_core
// Controller state and its update for a single word.
// ----------------------------------------------------------------------------
module atlc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  atlc_pkg::cfg_t  cfg,
    input  atlc_pkg::item_t item,
    input  logic            step_en,
    output atlc_pkg::res_t  res
);
    import atlc_pkg::*;

    logic [COUNT_BITS-1:0] counts_reg  [LANES];
    logic [COUNT_BITS-1:0] counts_next [LANES];
    logic [LANE_BITS-1:0]  active_reg, active_next;
    logic [GREEN_BITS-1:0] ticks_reg, ticks_next;
    logic                  emerg_reg, emerg_next;
    logic [HOLD_BITS-1:0]  hold_reg, hold_next;

    logic                  any_wait;
    logic                  any_wait_next;
    logic                  arrive_ok;
    logic [LANE_BITS-1:0]  arrive_idx;
    logic [SUM_BITS-1:0]   arrive_sum;
    logic [COUNT_BITS-1:0] arrive_sat;
    logic [CLAMP_BITS-1:0] g_lo;
    logic [CLAMP_BITS-1:0] g_hi;
    logic [GREEN_BITS-1:0] g;
    logic                  start;
    logic [LANE_BITS-1:0]  lane_a;
    logic [GREEN_BITS-1:0] t_a;
    logic                  green;
    logic                  passed;
    logic [HOLD_BITS-1:0]  hold_dec;

    always_comb begin
        any_wait = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            any_wait = any_wait | (counts_reg[i] != '0);
        end
    end

    // arrival
    assign arrive_ok  = (int'(item.lane) < LANES);
    assign arrive_idx = LANE_BITS'(item.lane);
    assign arrive_sum = SUM_BITS'(counts_reg[arrive_idx]) + SUM_BITS'(item.vehicles);
    assign arrive_sat = (arrive_sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                           : COUNT_BITS'(arrive_sum);

    // phase length clamp
    assign g_lo = (CLAMP_BITS'(counts_reg[active_reg]) < CLAMP_BITS'(cfg.min_green))
                  ? CLAMP_BITS'(cfg.min_green) : CLAMP_BITS'(counts_reg[active_reg]);
    assign g_hi = (g_lo > CLAMP_BITS'(cfg.max_green)) ? CLAMP_BITS'(cfg.max_green) : g_lo;
    assign g    = GREEN_BITS'(g_hi);

    assign start    = (ticks_reg == '0) && any_wait;
    assign lane_a   = (start && g == '0) ? next_lane(active_reg) : active_reg;
    assign t_a      = start ? g : ticks_reg;
    assign hold_dec = (hold_reg != '0) ? hold_reg - HOLD_BITS'(1) : hold_reg;

    always_comb begin
        counts_next = counts_reg;
        active_next = active_reg;
        ticks_next  = ticks_reg;
        emerg_next  = emerg_reg;
        hold_next   = hold_reg;
        green       = 1'b0;
        passed      = 1'b0;
        unique case (item.operation)
            OP_ARRIVAL: begin
                if (arrive_ok) begin
                    counts_next[arrive_idx] = arrive_sat;
                end
            end
            OP_EMERGENCY: begin
                emerg_next = 1'b1;
                hold_next  = cfg.emergency_ticks;
            end
            OP_TICK: begin
                if (emerg_reg) begin
                    hold_next  = hold_dec;
                    emerg_next = (hold_dec != '0);
                end else begin
                    active_next = lane_a;
                    ticks_next  = t_a;
                    if (t_a != '0) begin
                        green      = 1'b1;
                        ticks_next = t_a - GREEN_BITS'(1);
                        if (counts_reg[lane_a] != '0) begin
                            passed              = 1'b1;
                            counts_next[lane_a] = counts_reg[lane_a] - COUNT_BITS'(1);
                        end
                        if (t_a == GREEN_BITS'(1)) begin
                            active_next = next_lane(lane_a);
                        end
                    end
                end
            end
            default: begin
                counts_next = counts_reg;
            end
        endcase
    end

    always_comb begin
        any_wait_next = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            any_wait_next = any_wait_next | (counts_next[i] != '0);
        end
    end

    always_comb begin
        res.current_lane   = LANE_W'(active_next);
        res.light_green    = green;
        res.vehicle_passed = passed;
        res.lane_remaining = REM_BITS'(counts_next[active_next]);
        res.green_left     = ticks_next;
        res.emergency_hold = emerg_next;
        res.idle           = !any_wait_next && (ticks_next == '0) && !emerg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                counts_reg[i] <= '0;
            end
            active_reg <= '0;
            ticks_reg  <= '0;
            emerg_reg  <= 1'b0;
            hold_reg   <= '0;
        end else if (step_en) begin
            counts_reg <= counts_next;
            active_reg <= active_next;
            ticks_reg  <= ticks_next;
            emerg_reg  <= emerg_next;
            hold_reg   <= hold_next;
        end
    end

endmodule
